@@ hw/rtl/tea_pkg.sv @@
// Shared constants and types for the TEA block cipher.
`default_nettype none

package tea_pkg;

    localparam int unsigned TEA_ROUNDS = 32;
    localparam int unsigned TEA_WORD_W = 32;

    localparam logic [TEA_WORD_W-1:0] TEA_DELTA     = 32'h9e37_79b9;
    localparam logic [TEA_WORD_W-1:0] TEA_KEY_RESET = 32'hC6EF_3720;

    localparam int unsigned TEA_KEY_WORDS = 4;

    typedef logic [TEA_WORD_W-1:0] t_word;
    typedef logic [1:0]            t_cfg_idx;

    localparam t_cfg_idx CFG_KEY0 = 2'd0;
    localparam t_cfg_idx CFG_KEY1 = 2'd1;
    localparam t_cfg_idx CFG_KEY2 = 2'd2;
    localparam t_cfg_idx CFG_KEY3 = 2'd3;

    typedef enum logic {
        OP_ENCRYPT = 1'b0,
        OP_DECRYPT = 1'b1
    } t_opcode;

endpackage

`default_nettype wire

@@ hw/rtl/tea_block_cipher.sv @@
// TEA block cipher: fully unrolled pipeline, one half round per stage.
`default_nettype none

// Takes one 64-bit block per clock with no gaps: o_busy never rises and start
// may be held high every cycle. Each half round (one 32-bit word update) has
// its own register stage behind an input capture register, and each block
// leaves marked by a one-cycle o_done pulse. Results come out in input order
// and cannot be held off. The four key words are written over the cfg port
// (always ready) and reset to 0xC6EF3720; change them only while no block is
// in flight, since every stage reads them live.
module tea_block_cipher #(
    parameter int unsigned ROUNDS = tea_pkg::TEA_ROUNDS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    output logic                   o_busy,
    input  wire logic              i_opcode,
    input  wire tea_pkg::t_word    i_half_first,
    input  wire tea_pkg::t_word    i_half_second,
    output logic                   o_done,
    output tea_pkg::t_word         o_out_first,
    output tea_pkg::t_word         o_out_second,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire tea_pkg::t_cfg_idx i_cfg_index,
    input  wire tea_pkg::t_word    i_cfg_data
);
    import tea_pkg::*;

    localparam int unsigned NST = 2 * ROUNDS;

    t_word r_key [TEA_KEY_WORDS];

    logic  r_vld [NST+1];
    logic  r_op  [NST+1];
    t_word r_a   [NST+1];
    t_word r_b   [NST+1];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // key registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TEA_KEY_WORDS; k++) begin
                r_key[k] <= TEA_KEY_RESET;
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op[0] <= i_opcode;
        r_a[0]  <= i_half_first;
        r_b[0]  <= i_half_second;
    end

    for (genvar s = 0; s < NST; s++) begin : g_stage
        localparam int unsigned Rnd   = s / 2;
        localparam int unsigned Phase = s % 2;
        localparam logic [63:0] EncProd = 64'(Rnd + 1) * 64'(TEA_DELTA);
        localparam logic [63:0] DecProd = 64'(ROUNDS - Rnd) * 64'(TEA_DELTA);
        localparam t_word SumEnc = EncProd[TEA_WORD_W-1:0];
        localparam t_word SumDec = DecProd[TEA_WORD_W-1:0];

        logic  upd_a;
        logic  is_enc;
        t_word src;
        t_word dst;
        t_word ka;
        t_word kb;
        t_word sum;
        t_word mix;
        t_word upd;
        t_word n_a;
        t_word n_b;

        // enc: a then b per round; dec: b then a
        always_comb begin
            is_enc = (r_op[s] == OP_ENCRYPT);
            upd_a  = (is_enc == (Phase == 0));
            src    = upd_a ? r_b[s] : r_a[s];
            dst    = upd_a ? r_a[s] : r_b[s];
            ka     = upd_a ? r_key[CFG_KEY0] : r_key[CFG_KEY2];
            kb     = upd_a ? r_key[CFG_KEY1] : r_key[CFG_KEY3];
            sum    = is_enc ? SumEnc : SumDec;
            mix    = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
            upd    = is_enc ? (dst + mix) : (dst - mix);
            n_a    = upd_a ? upd : r_a[s];
            n_b    = upd_a ? r_b[s] : upd;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else begin
                r_vld[s+1] <= r_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            r_op[s+1] <= r_op[s];
            r_a[s+1]  <= n_a;
            r_b[s+1]  <= n_b;
        end
    end

    assign o_done       = r_vld[NST];
    assign o_out_first  = r_a[NST];
    assign o_out_second = r_b[NST];

    a_done_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && i_rst_n, NST + 1))
        else $error("result strobe without matching accepted item");

    a_op_travels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_op[NST] == $past(i_opcode, NST + 1)))
        else $error("opcode lost its item in the pipeline");

    a_key_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && i_cfg_index == CFG_KEY0) |=> (r_key[CFG_KEY0] == $past(i_cfg_data)))
        else $error("key word write not applied");

endmodule

`default_nettype wire
